### rtl/core/llwam_pkg.sv
// Shared types, category codes and constants for the load level monitor.
`default_nettype none

package llwam_pkg;

    // Category codes; the bit index in every flag mask equals the code.
    localparam logic [2:0] CAT_DIST    = 3'd0;
    localparam logic [2:0] CAT_STORAGE = 3'd1;
    localparam logic [2:0] CAT_INBUF   = 3'd2;
    localparam logic [2:0] CAT_RDA     = 3'd3;
    localparam logic [2:0] CAT_RPG     = 3'd4;
    localparam logic [2:0] CAT_WB      = 3'd5;

    localparam int NUM_CATEGORIES = 6;
    localparam int NUM_REGS       = 5;

    // Request kinds.
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CAT = 1'b1;

    localparam logic [6:0]  LEVEL_MAX    = 7'd100;
    localparam logic [15:0] THRESH_RESET = 16'h5A50;

    // APB register indexes.
    localparam logic [2:0] REG_PROD_DIST    = 3'd0;
    localparam logic [2:0] REG_PROD_STORAGE = 3'd1;
    localparam logic [2:0] REG_RDA_RADIAL   = 3'd2;
    localparam logic [2:0] REG_RPG_RADIAL   = 3'd3;
    localparam logic [2:0] REG_WB_USER      = 3'd4;

    // Category governed by each threshold register.
    localparam logic [2:0] REG_CATEGORY [NUM_REGS] = '{
        CAT_DIST, CAT_STORAGE, CAT_RDA, CAT_RPG, CAT_WB
    };

    typedef logic [6:0]  level_t;
    typedef logic [5:0]  flags_t;
    typedef logic [15:0] thresh_t;
    typedef thresh_t [NUM_REGS-1:0] thresh_bank_t;

    typedef struct packed {
        logic       req_type;
        logic [2:0] category;
        logic [7:0] new_level;
    } request_t;

    typedef struct packed {
        logic   flags_changed;
        flags_t alarm_cleared;
        flags_t alarm_raised;
        flags_t warn_cleared;
        flags_t warn_raised;
        flags_t alarm_flags;
        flags_t warn_flags;
        level_t read_level;
        logic   status;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/llwam_cfg.sv
// APB register file holding the warning and alarm thresholds.
`default_nettype none

module llwam_cfg
    import llwam_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output thresh_bank_t      thresholds
);

    logic [2:0]   reg_idx;
    logic         wr_en;
    thresh_bank_t thr_reg;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Threshold registers; writes past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                thr_reg[i] <= THRESH_RESET;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (reg_idx == 3'(i))
                begin
                    thr_reg[i] <= pwdata[15:0];
                end
            end
        end
    end

    // Read mux.
    always_comb
    begin
        prdata = 32'd0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (reg_idx == 3'(i))
            begin
                prdata = {16'd0, thr_reg[i]};
            end
        end
    end

    assign thresholds = thr_reg;

endmodule

`default_nettype wire

### rtl/core/llwam_core.sv
// Level store, flag state and single-pass threshold evaluation.
`default_nettype none

module llwam_core
    import llwam_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fire,
    input  request_t          req,
    input  thresh_bank_t      thresholds,
    output result_t           result
);

    level_t levels_reg [NUM_CATEGORIES];
    level_t levels_next [NUM_CATEGORIES];
    flags_t warn_reg;
    flags_t warn_next;
    flags_t alarm_reg;
    flags_t alarm_next;

    logic   cat_valid;
    logic   is_set;
    level_t sat_level;
    flags_t eval_warn;
    flags_t eval_alarm;
    flags_t w_raised;
    flags_t w_cleared;
    flags_t a_raised;
    flags_t a_cleared;
    level_t level_out;

    assign cat_valid = (req.category < 3'(NUM_CATEGORIES));
    assign is_set    = (req.req_type == REQ_SET);
    assign sat_level = (req.new_level > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : req.new_level[6:0];

    // Level store after this request's write.
    always_comb
    begin
        for (int i = 0; i < NUM_CATEGORIES; i++)
        begin
            if (is_set && cat_valid && (req.category == 3'(i)))
            begin
                levels_next[i] = sat_level;
            end
            else
            begin
                levels_next[i] = levels_reg[i];
            end
        end
    end

    // Compare each monitored category against its pair of thresholds.
    // The input buffer follows the two radial categories.
    always_comb
    begin
        eval_warn  = '0;
        eval_alarm = '0;
        for (int r = 0; r < NUM_REGS; r++)
        begin
            if ({1'b0, levels_next[REG_CATEGORY[r]]} >= thresholds[r][7:0])
            begin
                eval_warn[REG_CATEGORY[r]] = 1'b1;
            end
            if ({1'b0, levels_next[REG_CATEGORY[r]]} >= thresholds[r][15:8])
            begin
                eval_alarm[REG_CATEGORY[r]] = 1'b1;
            end
        end
        eval_warn[CAT_INBUF]  = eval_warn[CAT_RDA] | eval_warn[CAT_RPG];
        eval_alarm[CAT_INBUF] = eval_alarm[CAT_RDA] | eval_alarm[CAT_RPG];
    end

    // A read leaves the flags alone and reports no transitions.
    always_comb
    begin
        if (is_set)
        begin
            warn_next  = eval_warn;
            alarm_next = eval_alarm;
        end
        else
        begin
            warn_next  = warn_reg;
            alarm_next = alarm_reg;
        end
        w_raised  = warn_next & ~warn_reg;
        w_cleared = warn_reg & ~warn_next;
        a_raised  = alarm_next & ~alarm_reg;
        a_cleared = alarm_reg & ~alarm_next;
        level_out = '0;
        for (int i = 0; i < NUM_CATEGORIES; i++)
        begin
            if (req.category == 3'(i))
            begin
                level_out = levels_next[i];
            end
        end
    end

    // State update when the request leaves for the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CATEGORIES; i++)
            begin
                levels_reg[i] <= '0;
            end
            warn_reg  <= '0;
            alarm_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_CATEGORIES; i++)
            begin
                levels_reg[i] <= levels_next[i];
            end
            warn_reg  <= warn_next;
            alarm_reg <= alarm_next;
        end
    end

    always_comb
    begin
        result.status        = cat_valid ? STATUS_OK : STATUS_BAD_CAT;
        result.read_level    = level_out;
        result.warn_flags    = warn_next;
        result.alarm_flags   = alarm_next;
        result.warn_raised   = w_raised;
        result.warn_cleared  = w_cleared;
        result.alarm_raised  = a_raised;
        result.alarm_cleared = a_cleared;
        result.flags_changed = |{w_raised, w_cleared, a_raised, a_cleared};
    end

    // A read request must not disturb the flag state.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.req_type == REQ_READ) |=> $stable(warn_reg) && $stable(alarm_reg))
        else $error("flag state changed on a read request");

    // The input buffer flags always track the two radial categories.
    assert property (@(posedge clk) disable iff (!rst_n)
        (warn_reg[CAT_INBUF] == (warn_reg[CAT_RDA] | warn_reg[CAT_RPG])) &&
        (alarm_reg[CAT_INBUF] == (alarm_reg[CAT_RDA] | alarm_reg[CAT_RPG])))
        else $error("input buffer flags out of step with radial flags");

    // Stored levels never exceed the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (levels_reg[0] <= LEVEL_MAX) && (levels_reg[1] <= LEVEL_MAX) &&
        (levels_reg[2] <= LEVEL_MAX) && (levels_reg[3] <= LEVEL_MAX) &&
        (levels_reg[4] <= LEVEL_MAX) && (levels_reg[5] <= LEVEL_MAX))
        else $error("stored level above saturation limit");

    // The input buffer level is never written by anything but a set to it.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !(is_set && (req.category == CAT_INBUF)) |=> $stable(levels_reg[2]))
        else $error("input buffer level changed without a set to it");

endmodule

`default_nettype wire

### rtl/core/load_level_warn_alarm_monitor_top.sv
// Top level of the load level warning and alarm monitor.
//
// Requests arrive on the s_axis channel, one beat per request: tuser[0]
// is the request kind (set level or read level) and tdata carries the
// category code and the new level. Each request yields exactly one result
// beat on m_axis with the status, the stored level, the warning and alarm
// masks and their raised/cleared transitions.
// Thresholds live in five APB registers. The user must see that they are written
// only while the block is idle; the block does not enforce it. pready is tied high.
// An accepted request goes to the request register, where the level store is
// read, written and compared against the thresholds, and then to the result
// register, which holds its result beat.
// Throughput is one request per cycle while m_axis_tready stays high; the level
// and flag state is read and written in the same stage, so consecutive requests
// see each other's updates without stalls.
// When the receiver stalls, the result register holds its beat and the
// request register keeps one more request, then s_axis_tready drops.
// Reset clears all levels and flags and loads every threshold register
// with warning 80 and alarm 90; no beats are pending after reset.
`default_nettype none

module load_level_warn_alarm_monitor_top
    import llwam_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Request stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: category [2:0], new_level [10:3], zero [15:11].
    input  wire logic [15:0]  s_axis_tdata,
    // tuser: req_type [0].
    input  wire logic [0:0]   s_axis_tuser,
    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status [0], read_level [7:1], warn_flags [13:8],
    // alarm_flags [19:14], warn_raised [25:20], warn_cleared [31:26],
    // alarm_raised [37:32], alarm_cleared [43:38], flags_changed [44],
    // zero [47:45].
    output logic [47:0]       m_axis_tdata,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    thresh_bank_t thresholds;
    request_t     req_reg;
    logic         req_valid_reg;
    result_t      res_reg;
    result_t      res_comb;
    logic         res_valid_reg;
    logic         in_fire;
    logic         adv;

    llwam_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .thresholds (thresholds)
    );

    // Pipeline handshake: the request moves on whenever the result slot frees.
    assign adv           = req_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !req_valid_reg || adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                req_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg.req_type  <= s_axis_tuser[0];
            req_reg.category  <= s_axis_tdata[2:0];
            req_reg.new_level <= s_axis_tdata[10:3];
        end
        if (adv)
        begin
            res_reg <= res_comb;
        end
    end

    llwam_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (adv),
        .req        (req_reg),
        .thresholds (thresholds),
        .result     (res_comb)
    );

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {3'd0, res_reg};

    // A held request is never lost while the result slot is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !adv |=> req_valid_reg)
        else $error("pending request dropped");

    // A result beat that is not taken is not overwritten by a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !m_axis_tready |-> !adv)
        else $error("result register overwritten while stalled");

    // Every result is preceded by a request held in the request register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(req_valid_reg))
        else $error("result produced without a request");

endmodule

`default_nettype wire

### test/load_level_warn_alarm_monitor_top_test.sv
// Self-checking testbench for the load level warning and alarm monitor top level.
`timescale 1ns / 1ps

module load_level_warn_alarm_monitor_top_test
    import llwam_pkg::*;
();

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 275;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    load_level_warn_alarm_monitor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow copy of the block state and its threshold registers.
    level_t  shadow_levels [NUM_CATEGORIES];
    flags_t  shadow_warn;
    flags_t  shadow_alarm;
    thresh_t shadow_thresh [NUM_REGS];

    request_t request_backlog [$];
    result_t  predicted_reports [$];
    request_t cur_req = '0;

    int   err_count = 0;
    int   cycle_count = 0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   hold_count = 0;
    logic no_idle = 1'b0;
    logic hold_armed = 1'b0;
    logic rx_hold = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Compute the report of one request and advance the shadow state.
    function automatic result_t predict_report(request_t rq);
        result_t rep;
        flags_t  nw;
        flags_t  na;
        logic    valid;
        logic [2:0] cat;
        rep = '0;
        valid = (rq.category < NUM_CATEGORIES);
        if (rq.req_type == REQ_SET)
        begin
            if (valid)
            begin
                shadow_levels[rq.category] =
                    (rq.new_level > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : rq.new_level[6:0];
            end
            nw = '0;
            na = '0;
            for (int r = 0; r < NUM_REGS; r++)
            begin
                cat = REG_CATEGORY[r];
                if ({1'b0, shadow_levels[cat]} >= shadow_thresh[r][7:0])
                    nw[cat] = 1'b1;
                if ({1'b0, shadow_levels[cat]} >= shadow_thresh[r][15:8])
                    na[cat] = 1'b1;
            end
            // The input buffer follows the two radial categories.
            if (nw[CAT_RDA] | nw[CAT_RPG])
                nw[CAT_INBUF] = 1'b1;
            if (na[CAT_RDA] | na[CAT_RPG])
                na[CAT_INBUF] = 1'b1;
            rep.warn_raised   = nw & ~shadow_warn;
            rep.warn_cleared  = shadow_warn & ~nw;
            rep.alarm_raised  = na & ~shadow_alarm;
            rep.alarm_cleared = shadow_alarm & ~na;
            shadow_warn  = nw;
            shadow_alarm = na;
        end
        rep.status        = valid ? STATUS_OK : STATUS_BAD_CAT;
        rep.read_level    = valid ? shadow_levels[rq.category] : '0;
        rep.warn_flags    = shadow_warn;
        rep.alarm_flags   = shadow_alarm;
        rep.flags_changed = |{rep.warn_raised, rep.warn_cleared,
                              rep.alarm_raised, rep.alarm_cleared};
        return rep;
    endfunction

    // Compare one result beat with its prediction, field by field.
    task automatic check_report(input result_t want, input logic [47:0] beat);
        result_t got;
        got = result_t'(beat[44:0]);
        if (got.status !== want.status || got.read_level !== want.read_level ||
            got.warn_flags !== want.warn_flags || got.alarm_flags !== want.alarm_flags ||
            got.warn_raised !== want.warn_raised || got.warn_cleared !== want.warn_cleared ||
            got.alarm_raised !== want.alarm_raised ||
            got.alarm_cleared !== want.alarm_cleared ||
            got.flags_changed !== want.flags_changed || beat[47:45] !== 3'b000)
        begin
            err_count++;
            if (err_count <= 10)
            begin
                $display({"mismatch: expected st=%0d lvl=%0d w=%h a=%h",
                          " wr=%h wc=%h ar=%h ac=%h ch=%0d"},
                         want.status, want.read_level, want.warn_flags, want.alarm_flags,
                         want.warn_raised, want.warn_cleared, want.alarm_raised,
                         want.alarm_cleared, want.flags_changed);
                $display({"          actual   st=%0d lvl=%0d w=%h a=%h",
                          " wr=%h wc=%h ar=%h ac=%h ch=%0d pad=%0d"},
                         got.status, got.read_level, got.warn_flags, got.alarm_flags,
                         got.warn_raised, got.warn_cleared, got.alarm_raised,
                         got.alarm_cleared, got.flags_changed, beat[47:45]);
            end
        end
    endtask

    // Request driver: presents backlog entries with a random gap after each beat, no gap while no_idle is set.
    always @(posedge clk or negedge rst_n)
    begin
        int   gap_next;
        logic valid_next;
        logic accepted;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            tx_gap        <= 0;
        end
        else
        begin
            gap_next = tx_gap;
            valid_next = s_axis_tvalid;
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted)
            begin
                predicted_reports.push_back(predict_report(cur_req));
                gap_next = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (!s_axis_tvalid || accepted)
            begin
                if (gap_next > 0)
                begin
                    gap_next = gap_next - 1;
                    valid_next = 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    cur_req = request_backlog.pop_front();
                    valid_next = 1'b1;
                end
                else
                begin
                    valid_next = 1'b0;
                end
            end
            s_axis_tvalid <= valid_next;
            s_axis_tdata  <= {5'b0, cur_req.new_level, cur_req.category};
            s_axis_tuser  <= cur_req.req_type;
            tx_gap        <= gap_next;
        end
    end

    // Result monitor: checks every beat and stalls at random after each one, unless no_idle is set.
    always @(posedge clk or negedge rst_n)
    begin
        int wait_next;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end
        else
        begin
            wait_next = rx_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: result beat %h with no request pending",
                                 m_axis_tdata);
                end
                else
                begin
                    check_report(predicted_reports.pop_front(), m_axis_tdata);
                end
                wait_next = no_idle ? 0 : $urandom_range(0, 3);
            end
            else if (wait_next > 0)
            begin
                wait_next = wait_next - 1;
            end
            rx_wait       <= wait_next;
            m_axis_tready <= !rx_hold && (wait_next == 0);
        end
    end

    // Long receiver hold-off, counted here once armed, so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold    <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            rx_hold    <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            rx_hold <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_threshold(input int idx, input thresh_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_REGS)
            shadow_thresh[idx] = value;
    endtask

    // Wait until every request has been answered, then let the pipeline settle.
    task automatic wait_drained();
        do @(negedge clk);
        while (request_backlog.size() != 0 || s_axis_tvalid || predicted_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_req(input logic kind, input logic [2:0] cat, input logic [7:0] lvl);
        request_t rq;
        rq.req_type  = kind;
        rq.category  = cat;
        rq.new_level = lvl;
        request_backlog.push_back(rq);
    endtask

    // Random request, biased toward levels around the current thresholds.
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        int       r;
        logic [7:0] base;
        rq.req_type = ($urandom_range(0, 99) < 25) ? REQ_READ : REQ_SET;
        rq.category = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            r = $urandom_range(0, NUM_REGS - 1);
            base = $urandom_range(0, 1) ? shadow_thresh[r][7:0] : shadow_thresh[r][15:8];
            rq.category  = REG_CATEGORY[r];
            rq.new_level = base + 8'($urandom_range(0, 2)) - 8'd1;
        end
        else if (pick < 6)
        begin
            case ($urandom_range(0, 3))
                0: rq.new_level = 8'd0;
                1: rq.new_level = 8'd100;
                2: rq.new_level = 8'd101;
                default: rq.new_level = 8'd255;
            endcase
        end
        else
        begin
            rq.new_level = 8'($urandom_range(0, 255));
        end
        return rq;
    endfunction

    // Stimulus sequence.
    initial
    begin
        thresh_t tv;
        for (int i = 0; i < NUM_CATEGORIES; i++)
            shadow_levels[i] = '0;
        for (int i = 0; i < NUM_REGS; i++)
            shadow_thresh[i] = THRESH_RESET;
        shadow_warn  = '0;
        shadow_alarm = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset thresholds.
        push_req(REQ_READ, CAT_DIST, 8'd0);
        push_req(REQ_SET, CAT_DIST, 8'd255);
        push_req(REQ_SET, CAT_DIST, 8'd85);
        push_req(REQ_SET, CAT_DIST, 8'd79);
        push_req(REQ_SET, CAT_RDA, 8'd90);
        push_req(REQ_SET, CAT_RPG, 8'd80);
        push_req(REQ_SET, CAT_RDA, 8'd0);
        push_req(REQ_SET, CAT_RPG, 8'd101);
        push_req(REQ_SET, CAT_STORAGE, 8'd128);
        push_req(REQ_SET, CAT_WB, 8'd100);
        push_req(REQ_SET, CAT_INBUF, 8'd100);
        push_req(REQ_READ, CAT_INBUF, 8'd0);
        push_req(REQ_SET, 3'd6, 8'd50);
        push_req(REQ_READ, 3'd7, 8'd255);
        push_req(REQ_READ, CAT_WB, 8'd0);
        push_req(REQ_SET, CAT_WB, 8'd0);
        wait_drained();

        // Zero and maximal thresholds, re-evaluated through invalid categories.
        write_threshold(REG_PROD_DIST, 16'h0000);
        write_threshold(REG_RDA_RADIAL, 16'hFFFF);
        write_threshold(REG_RPG_RADIAL, 16'hFFFF);
        @(negedge clk);
        push_req(REQ_SET, 3'd7, 8'd0);
        push_req(REQ_READ, CAT_RPG, 8'd0);
        wait_drained();
        write_threshold(REG_PROD_DIST, 16'hFFFF);
        @(negedge clk);
        push_req(REQ_SET, 3'd6, 8'd255);
        push_req(REQ_READ, CAT_DIST, 8'd0);
        wait_drained();

        // Random phases, each under its own threshold setting.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case (p)
                    0: tv = THRESH_RESET;
                    1: tv = 16'($urandom);
                    2: tv = 16'h0000;
                    3: tv = 16'hFFFF;
                    4: tv = {8'($urandom_range(95, 105)), 8'($urandom_range(95, 105))};
                    default: tv = {8'($urandom_range(0, 100)), 8'($urandom_range(0, 100))};
                endcase
                write_threshold(r, tv);
            end
            // Writes beyond the last register must leave the thresholds alone.
            if (p == RANDOM_PHASES - 1)
            begin
                write_threshold(NUM_REGS, 16'($urandom));
                write_threshold(7, 16'($urandom));
            end
            @(negedge clk);
            no_idle <= (p == 1);
            if (p == 4)
                hold_armed <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                request_backlog.push_back(random_request());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (predicted_reports.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/llwam_pkg.sv
rtl/core/llwam_cfg.sv
rtl/core/llwam_core.sv
rtl/core/load_level_warn_alarm_monitor_top.sv
test/load_level_warn_alarm_monitor_top_test.sv
